// ===== hw/rtl/wtk_pkg.sv =====
// shared types, constants and helpers for the word tokenizer
package wtk_pkg;

	localparam int MAX_WORD     = 32;
	localparam int DICT_ENTRIES = 4096;
	localparam int ID_W         = 12;
	localparam int CNT_W        = $clog2(DICT_ENTRIES + 1);
	localparam int ADDR_W       = $clog2(DICT_ENTRIES);
	localparam int LEN_W        = $clog2(MAX_WORD + 1);
	localparam int POS_W        = $clog2(MAX_WORD);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EXCL  = 8'h21;
	localparam logic [7:0] CH_QUEST = 8'h3F;

	typedef logic [MAX_WORD-1:0][7:0] word_t;

	// lookup request handed from front to back
	typedef struct packed {
		word_t            bytes;
		logic [LEN_W-1:0] len;
		logic             cut;
		logic             has_mark;
		logic [7:0]       mark;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] token_id;
		logic            is_punct;
		logic            last_of_run;
		logic            truncated;
		logic            dict_full;
	} res_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_mark(input logic [7:0] c);
		return c == CH_COMMA || c == CH_SEMI || c == CH_COLON ||
			c == CH_DOT || c == CH_EXCL || c == CH_QUEST;
	endfunction

	// byte-wise mask covering the first len bytes
	function automatic word_t len_mask(input logic [LEN_W-1:0] len);
		word_t m;
		for (int i = 0; i < MAX_WORD; i++) begin
			m[i] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

// ===== hw/rtl/wtk_front.sv =====
// front end: collects word bytes, classifies delimiters, queues lookup requests
module wtk_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    text_byte,
	output logic          req_valid,
	output wtk_pkg::req_t req_data,
	input  logic          req_take
);
	import wtk_pkg::*;

	logic             in_word_q;
	logic             cut_q;
	logic [LEN_W-1:0] len_q;
	word_t            buf_q;

	req_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	logic accept, is_space, is_mk, enq, deq;

	assign full      = (cnt_q == 2'd2);
	assign accept    = push && !full;
	assign is_space  = (text_byte == CH_SPACE) || (text_byte == CH_NL);
	assign is_mk     = is_mark(text_byte);
	assign enq       = accept && in_word_q && (is_space || is_mk);
	assign req_valid = (cnt_q != 2'd0);
	assign deq       = req_take && req_valid;
	assign req_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			cut_q     <= 1'b0;
			len_q     <= '0;
		end else if (accept) begin
			if (!in_word_q) begin
				if (is_letter(text_byte)) begin
					in_word_q <= 1'b1;
					cut_q     <= 1'b0;
					len_q     <= LEN_W'(1);
				end
			end else if (!is_space && !is_mk) begin
				if (len_q < LEN_W'(MAX_WORD))
					len_q <= len_q + LEN_W'(1);
				else
					cut_q <= 1'b1;
			end else begin
				in_word_q <= 1'b0;
				len_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!in_word_q)
				buf_q[0] <= text_byte;
			else if (!is_space && !is_mk && len_q < LEN_W'(MAX_WORD))
				buf_q[len_q[POS_W-1:0]] <= text_byte;
		end
		if (enq) begin
			fifo_q[wr_ptr_q] <= '{bytes: buf_q, len: len_q, cut: cut_q,
				has_mark: is_mk, mark: text_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (enq)
				wr_ptr_q <= ~wr_ptr_q;
			if (deq)
				rd_ptr_q <= ~rd_ptr_q;
			case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/wtk_back.sv =====
// back end: dictionary search and append, result queue
module wtk_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  wtk_pkg::req_t req_data,
	output logic          req_take,
	output logic          empty,
	input  logic          pop,
	output wtk_pkg::res_t res_head
);
	import wtk_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_CMP, ST_EMIT} state_t;

	typedef struct packed {
		word_t            bytes;
		logic [LEN_W-1:0] len;
	} entry_t;

	entry_t mem [DICT_ENTRIES];
	entry_t rd_q;

	state_t           state_q;
	word_t            key_q;
	logic [LEN_W-1:0] klen_q;
	logic             cut_q, has_mark_q, phase_mark_q;
	logic [7:0]       mark_q;
	logic [CNT_W-1:0] idx_q, count_q;
	logic [ID_W-1:0]  id_q;
	logic             full_q;

	res_t       rfifo_q [4];
	logic [1:0] rwr_q, rrd_q;
	logic [2:0] rcnt_q;

	logic miss, room, hit, rpush, rpop;
	res_t rnew;

	assign miss     = (idx_q == count_q);
	assign room     = (count_q < CNT_W'(DICT_ENTRIES));
	assign hit      = (rd_q.len == klen_q) &&
		(((rd_q.bytes ^ key_q) & len_mask(klen_q)) == '0);
	assign req_take = (state_q == ST_IDLE) && req_valid;
	assign rpush    = (state_q == ST_EMIT) && (rcnt_q != 3'd4);
	assign rpop     = pop && !empty;
	assign empty    = (rcnt_q == 3'd0);
	assign res_head = rfifo_q[rrd_q];
	assign rnew     = '{token_id: id_q, is_punct: phase_mark_q,
		last_of_run: phase_mark_q || !has_mark_q,
		truncated: !phase_mark_q && cut_q, dict_full: full_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			phase_mark_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						idx_q        <= '0;
						phase_mark_q <= 1'b0;
						state_q      <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (miss) begin
						if (room)
							count_q <= count_q + CNT_W'(1);
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (hit) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= ST_LOOK;
					end
				end
				ST_EMIT: begin
					if (rpush) begin
						if (!phase_mark_q && has_mark_q) begin
							// mark is looked up as a one-byte word
							phase_mark_q <= 1'b1;
							idx_q        <= '0;
							state_q      <= ST_LOOK;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			key_q      <= req_data.bytes;
			klen_q     <= req_data.len;
			cut_q      <= req_data.cut;
			has_mark_q <= req_data.has_mark;
			mark_q     <= req_data.mark;
		end
		if (state_q == ST_LOOK && miss) begin
			id_q   <= room ? count_q[ID_W-1:0] : '0;
			full_q <= !room;
		end
		if (state_q == ST_CMP && hit) begin
			id_q   <= idx_q[ID_W-1:0];
			full_q <= 1'b0;
		end
		if (rpush && !phase_mark_q && has_mark_q) begin
			key_q  <= {{(MAX_WORD-1){8'h00}}, mark_q};
			klen_q <= LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			if (miss && room)
				mem[count_q[ADDR_W-1:0]] <= '{bytes: key_q, len: klen_q};
			rd_q <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (rpush)
			rfifo_q[rwr_q] <= rnew;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_q  <= '0;
			rrd_q  <= '0;
			rcnt_q <= '0;
		end else begin
			if (rpush)
				rwr_q <= rwr_q + 2'd1;
			if (rpop)
				rrd_q <= rrd_q + 2'd1;
			case ({rpush, rpop})
				2'b10:   rcnt_q <= rcnt_q + 3'd1;
				2'b01:   rcnt_q <= rcnt_q - 3'd1;
				default: rcnt_q <= rcnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/word_tokenizer_id_assigner.sv =====
// top level of the word tokenizer that assigns dense ids to words
// Bytes enter through push/full and the front end takes one byte per cycle while its two-deep
// request queue has room; a word end turns into a dictionary lookup. The back end searches the
// dictionary linearly, reading and then comparing one stored entry at a time, and a word closed
// by punctuation costs a second lookup for the mark. Results collect in a four-deep queue read
// through empty/pop. No clearing pass is needed after reset: the dictionary word count starts at
// zero.
module word_tokenizer_id_assigner (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                text_byte,
	output logic                      empty,
	input  logic                      pop,
	output logic [wtk_pkg::ID_W-1:0]  token_id,
	output logic                      is_punct,
	output logic                      last_of_run,
	output logic                      truncated,
	output logic                      dict_full
);
	import wtk_pkg::*;

	logic req_valid, req_take;
	req_t req_data;
	res_t res_head;

	wtk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text_byte (text_byte),
		.req_valid (req_valid),
		.req_data  (req_data),
		.req_take  (req_take)
	);

	wtk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_data  (req_data),
		.req_take  (req_take),
		.empty     (empty),
		.pop       (pop),
		.res_head  (res_head)
	);

	assign token_id    = res_head.token_id;
	assign is_punct    = res_head.is_punct;
	assign last_of_run = res_head.last_of_run;
	assign truncated   = res_head.truncated;
	assign dict_full   = res_head.dict_full;

endmodule

// ===== tb/sv/wtk_checker.sv =====
// checker for the word tokenizer: predicts token ids and compares results
`timescale 1ns / 1ps
module wtk_checker
	import wtk_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  logic [7:0]      text_byte,
	input  logic            empty,
	input  logic            pop,
	input  logic [ID_W-1:0] token_id,
	input  logic            is_punct,
	input  logic            last_of_run,
	input  logic            truncated,
	input  logic            dict_full,
	output int              errors,
	output int              pending,
	output int              n_results,
	output int              n_words
);

	res_t  token_q[$];
	word_t dict_w[$];
	int    dict_len[$];
	word_t cur_word;
	int    cur_len;
	bit    in_word;
	bit    cur_cut;

	assign pending = token_q.size();
	assign n_words = dict_w.size();

	// exact match on length and bytes, append on a miss while room is left
	function automatic logic [ID_W-1:0] lookup_word(input word_t w, input int len,
			output bit no_room);
		no_room = 0;
		for (int e = 0; e < dict_w.size(); e++) begin
			if (dict_len[e] == len && dict_w[e] == w) return e[ID_W-1:0];
		end
		if (dict_w.size() < DICT_ENTRIES) begin
			dict_w.push_back(w);
			dict_len.push_back(len);
			return ID_W'(dict_w.size() - 1);
		end
		no_room = 1;
		return '0;
	endfunction

	task automatic tokenize(input logic [7:0] c);
		bit    spc;
		bit    mk;
		bit    nf;
		res_t  r;
		word_t one;
		spc = (c == CH_SPACE || c == CH_NL);
		mk = (c == CH_COMMA || c == CH_SEMI || c == CH_COLON || c == CH_DOT ||
			c == CH_EXCL || c == CH_QUEST);
		if (!in_word) begin
			if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
				in_word = 1;
				cur_cut = 0;
				cur_word = '0;
				cur_word[0] = c;
				cur_len = 1;
			end
		end else if (!spc && !mk) begin
			if (cur_len < MAX_WORD) begin
				cur_word[cur_len] = c;
				cur_len++;
			end else begin
				cur_cut = 1;
			end
		end else begin
			r.token_id = lookup_word(cur_word, cur_len, nf);
			r.is_punct = 0;
			r.last_of_run = spc;
			r.truncated = cur_cut;
			r.dict_full = nf;
			token_q.push_back(r);
			in_word = 0;
			cur_cut = 0;
			if (mk) begin
				one = '0;
				one[0] = c;
				r.token_id = lookup_word(one, 1, nf);
				r.is_punct = 1;
				r.last_of_run = 1;
				r.truncated = 0;
				r.dict_full = nf;
				token_q.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q.delete();
			dict_w.delete();
			dict_len.delete();
			in_word = 0;
			cur_cut = 0;
			cur_len = 0;
			cur_word = '0;
			errors = 0;
			n_results = 0;
		end else begin
			if (pop && !empty) begin
				n_results++;
				if (token_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result id=%0d punct=%b", $realtime,
							token_id, is_punct);
				end else begin
					res_t e;
					e = token_q.pop_front();
					if (e.token_id !== token_id || e.is_punct !== is_punct ||
							e.last_of_run !== last_of_run || e.truncated !== truncated ||
							e.dict_full !== dict_full) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch exp id=%0d p=%b l=%b t=%b f=%b got id=%0d p=%b l=%b t=%b f=%b",
								$realtime, e.token_id, e.is_punct, e.last_of_run,
								e.truncated, e.dict_full, token_id, is_punct, last_of_run,
								truncated, dict_full);
					end
				end
			end
			if (push && !full) tokenize(text_byte);
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top for the word tokenizer: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;
	import wtk_pkg::*;

	logic            clk = 0;
	logic            arst_n = 0;
	logic            push = 0;
	logic [7:0]      text_byte = 8'h00;
	logic            pop = 0;
	logic            full;
	logic            empty;
	logic [ID_W-1:0] token_id;
	logic            is_punct;
	logic            last_of_run;
	logic            truncated;
	logic            dict_full;
	logic            full_n;
	int              errors;
	int              pending;
	int              n_results;
	int              n_words;
	int              n_bytes = 0;
	int              pop_gap = 0;
	bit              no_idle = 0;
	string           vocab[$];

	always #1 clk = ~clk;

	word_tokenizer_id_assigner DUT (.*);

	wtk_checker u_checker (.*);

	// full as seen just before each rising edge
	always @(negedge clk) full_n <= full;

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (no_idle || !arst_n) begin
			pop <= arst_n;
			pop_gap <= 0;
		end else if (pop_gap > 0) begin
			pop <= 0;
			pop_gap <= pop_gap - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			pop <= 0;
			pop_gap <= $urandom_range(0, 9);
		end else begin
			pop <= 1;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		push <= 1;
		text_byte <= b;
		do @(posedge clk); while (full_n);
		n_bytes++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic wait_drained;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_delim;
		case ($urandom_range(0, 7))
			0: return CH_SPACE;
			1: return CH_NL;
			2: return CH_COMMA;
			3: return CH_SEMI;
			4: return CH_COLON;
			5: return CH_DOT;
			6: return CH_EXCL;
			default: return CH_QUEST;
		endcase
	endfunction

	function automatic logic [7:0] pick_letter;
		return $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25)) :
			8'(8'h61 + $urandom_range(0, 25));
	endfunction

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		string w;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// letter extremes, every mark, marks and junk with no word pending
		send_text(", Az za\nZ;AZ:q.");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("b");
		send_byte(8'h80);
		send_byte(8'h7F);
		send_text("!k?? za ");
		// overlong word gets cut, then the same cut word again
		send_text("Mxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxx. ");
		send_text("Mxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxx\n");

		// sender holds off until everything is out
		push <= 0;
		wait_drained();

		for (int i = 0; i < 40; i++) begin
			w = "";
			repeat ($urandom_range(1, 6)) w = {w, string'(pick_letter())};
			vocab.push_back(w);
		end

		while (n_bytes < 440) begin
			if (n_bytes > 380) no_idle = 1;
			case ($urandom_range(0, 9))
				0: send_byte(8'($urandom_range(0, 255)));
				1: begin
					// word with odd bytes inside, sometimes overlong
					send_byte(pick_letter());
					repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) :
							$urandom_range(30, 38)) begin
						logic [7:0] b;
						b = 8'($urandom_range(0, 255));
						if (b == CH_SPACE || b == CH_NL || b == CH_COMMA || b == CH_SEMI ||
								b == CH_COLON || b == CH_DOT || b == CH_EXCL || b == CH_QUEST)
							b = 8'h5F;
						send_byte(b);
					end
					send_byte(pick_delim());
				end
				default: begin
					send_text(vocab[$urandom_range(0, vocab.size() - 1)]);
					send_byte(pick_delim());
				end
			endcase
		end
		// a word left open at the end produces nothing
		send_text("tail");
		push <= 0;

		wait_drained();
		repeat (200) @(posedge clk);
		$display("sent %0d text bytes, checked %0d results", n_bytes, n_results);
		$display("dictionary grew to %0d entries incl. cut words and marks", n_words);
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
